/* hdl/wip_pkg.sv */
// Package for the weighted interval placer: request and response structs,
// mode and status codes. No dependencies.
package wip_pkg;

   localparam logic [1:0] MODE_LOAD  = 2'd0;
   localparam logic [1:0] MODE_DRAW  = 2'd1;
   localparam logic [1:0] MODE_CLEAR = 2'd2;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_DONE    = 2'd1;
   localparam logic [1:0] STATUS_FULL    = 2'd2;
   localparam logic [1:0] STATUS_REFUSED = 2'd3;

   typedef struct packed {
      logic [1:0]  mode;
      logic [27:0] length_value;
      logic [31:0] fraction_draw;
      logic [31:0] position_draw;
      logic [27:0] interval_length;
   } req_type;

   typedef struct packed {
      logic [4:0]  chosen_index;
      logic [27:0] start_pos;
      logic [28:0] end_pos;
      logic [1:0]  status;
   } rsp_type;

endpackage

/* hdl/weighted_interval_placer.sv */
// Weighted interval placer: inverse-CDF selection over stored running sums
// and uniform placement of an interval. Depends on wip_pkg.
// Clear, a full table, an unused mode and an empty table give the result strobe straight
// from idle; a load passes through the load state. A draw reads the total, multiplies in
// two halves, runs at most ceil(log2(entry count)) binary search steps, each one read of
// the sum memory, then reads the chosen length and multiplies again if it exceeds the interval.
// One item at a time: busy is high until the result strobe. The receiver
// cannot stall. Reset empties the table; memory contents are not cleared.
module weighted_interval_placer #(
   parameter int MAX_SEQUENCES = 32,
   parameter int LENGTH_BITS   = 28
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  wip_pkg::req_type req_data,
   output logic             rsp_valid,
   output wip_pkg::rsp_type rsp_data
);
   import wip_pkg::*;

   localparam int LEN_W = LENGTH_BITS;
   localparam int CNT_W = $clog2(MAX_SEQUENCES + 1);
   localparam int IDX_W = $clog2(MAX_SEQUENCES);
   localparam int SUM_W = LENGTH_BITS + CNT_W;
   localparam int MB    = (SUM_W + 1) / 2;
   localparam int PW    = 32 + 2 * MB;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_LOAD   = 3'd1;
   localparam logic [2:0] ST_TOTAL  = 3'd2;
   localparam logic [2:0] ST_MUL_LO = 3'd3;
   localparam logic [2:0] ST_MUL_HI = 3'd4;
   localparam logic [2:0] ST_SEARCH = 3'd5;
   localparam logic [2:0] ST_LEN    = 3'd6;
   localparam logic [2:0] ST_DONE   = 3'd7;

   logic [SUM_W-1:0] sum_mem [MAX_SEQUENCES];
   logic [LEN_W-1:0] len_mem [MAX_SEQUENCES];

   logic [2:0]       state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   req_type          req_ff, req_in;
   logic [IDX_W-1:0] lo_ff, lo_in, hi_ff, hi_in, mid_ff, mid_in;
   logic [2*MB-1:0]  opnd_ff, opnd_in;
   logic [PW-1:0]    acc_ff, acc_in;
   logic             place_ff, place_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;

   logic [SUM_W-1:0] sum_rd_ff;
   logic [LEN_W-1:0] len_rd_ff;
   logic [IDX_W-1:0] sum_raddr, len_raddr;
   logic             mem_we;
   logic [SUM_W-1:0] sum_wdata;

   logic [CNT_W-1:0] cnt_m1;
   logic [63:0]      len_wide, span_wide;
   logic [LEN_W-1:0] load_len;
   logic [31:0]      mul_a;
   logic [MB-1:0]    mul_b;
   logic [PW-1:0]    product;
   logic             reach;
   logic [PW-1:0]    start_full, end_full;

   assign cnt_m1   = count_ff - 1'b1;
   assign len_wide = 64'(req_ff.length_value);
   assign load_len = len_wide[LEN_W-1:0];
   assign mul_a    = place_ff ? req_ff.position_draw : req_ff.fraction_draw;
   assign product  = PW'(mul_a) * PW'(mul_b);
   assign reach    = ((PW'(sum_rd_ff) << 32) >= acc_ff);
   assign span_wide = 64'(len_rd_ff) - 64'(req_ff.interval_length);
   assign start_full = (acc_ff >> 32) + PW'(1);
   assign end_full   = start_full + PW'(req_ff.interval_length);
   assign sum_wdata  = ((count_ff == '0) ? '0 : sum_rd_ff) + SUM_W'(load_len);

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      req_in       = req_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      mid_in       = mid_ff;
      opnd_in      = opnd_ff;
      acc_in       = acc_ff;
      place_in     = place_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = '0;
      rsp_in.status = STATUS_REFUSED;
      sum_raddr    = cnt_m1[IDX_W-1:0];
      len_raddr    = lo_ff;
      mem_we       = 1'b0;
      mul_b        = opnd_ff[MB-1:0];
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               req_in   = req_data;
               place_in = 1'b0;
               lo_in    = '0;
               hi_in    = cnt_m1[IDX_W-1:0];
               case (req_data.mode)
                  MODE_LOAD: begin
                     if (count_ff == CNT_W'(MAX_SEQUENCES)) begin
                        rsp_valid_in  = 1'b1;
                        rsp_in.status = STATUS_FULL;
                     end else begin
                        state_in = ST_LOAD;
                     end
                  end
                  MODE_CLEAR: begin
                     count_in      = '0;
                     rsp_valid_in  = 1'b1;
                     rsp_in.status = STATUS_DONE;
                  end
                  MODE_DRAW: begin
                     if (count_ff == '0) begin
                        rsp_valid_in = 1'b1;
                     end else begin
                        state_in = ST_TOTAL;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         ST_LOAD: begin
            mem_we        = 1'b1;
            count_in      = count_ff + 1'b1;
            rsp_valid_in  = 1'b1;
            rsp_in.status = STATUS_DONE;
            state_in      = ST_IDLE;
         end
         ST_TOTAL: begin
            opnd_in  = (2*MB)'(sum_rd_ff);
            state_in = ST_MUL_LO;
         end
         ST_MUL_LO: begin
            mul_b    = opnd_ff[MB-1:0];
            acc_in   = product;
            state_in = ST_MUL_HI;
         end
         ST_MUL_HI: begin
            mul_b  = opnd_ff[2*MB-1:MB];
            acc_in = acc_ff + (product << MB);
            if (place_ff) begin
               state_in = ST_DONE;
            end else if (lo_ff < hi_ff) begin
               mid_in    = lo_ff + ((hi_ff - lo_ff) >> 1);
               sum_raddr = mid_in;
               state_in  = ST_SEARCH;
            end else begin
               len_raddr = lo_ff;
               state_in  = ST_LEN;
            end
         end
         ST_SEARCH: begin
            if (reach) begin
               hi_in = mid_ff;
            end else begin
               lo_in = mid_ff + 1'b1;
            end
            if (lo_in < hi_in) begin
               mid_in    = lo_in + ((hi_in - lo_in) >> 1);
               sum_raddr = mid_in;
            end else begin
               len_raddr = lo_in;
               state_in  = ST_LEN;
            end
         end
         ST_LEN: begin
            if (64'(len_rd_ff) > 64'(req_ff.interval_length)) begin
               opnd_in  = (2*MB)'(span_wide);
               place_in = 1'b1;
               state_in = ST_MUL_LO;
            end else begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_DONE: begin
            rsp_valid_in        = 1'b1;
            rsp_in.status       = STATUS_OK;
            rsp_in.chosen_index = 5'(lo_ff);
            rsp_in.start_pos    = 28'(start_full);
            rsp_in.end_pos      = 29'(end_full);
            state_in            = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         sum_mem[count_ff[IDX_W-1:0]] <= sum_wdata;
         len_mem[count_ff[IDX_W-1:0]] <= load_len;
      end
      sum_rd_ff <= sum_mem[sum_raddr];
      len_rd_ff <= len_mem[len_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff   <= req_in;
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
      mid_ff   <= mid_in;
      opnd_ff  <= opnd_in;
      acc_ff   <= acc_in;
      place_ff <= place_in;
      rsp_ff   <= rsp_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_rsp_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("Result strobe while an item is still in progress.");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_SEQUENCES))
      else $error("Entry count exceeds the table depth.");

   a_search_window: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SEARCH) |-> (lo_ff < hi_ff && mid_ff >= lo_ff && mid_ff < hi_ff))
      else $error("Binary search window is empty or the probe lies outside it.");

   a_load_grows: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOAD) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("A load did not advance the entry count.");

endmodule
